// ===== design/smau_pkg.sv =====
// shared constants and types for the stack machine arithmetic unit
package smau_pkg;

  localparam int STACK_DEPTH   = 256;
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int WORD_W        = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 9;
  localparam int MIN_OPERANDS  = 2;
  localparam int DIV_STEP_W    = $clog2(WORD_W);

  localparam int IN_FIELDS_W   = OP_W + WORD_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = STATUS_W + WORD_W + COUNT_OUT_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

// ===== design/smau_div.sv =====
// iterative signed 32-bit divider, one quotient bit per cycle, truncating
module smau_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [smau_pkg::WORD_W-1:0] dividend,
  input  logic [smau_pkg::WORD_W-1:0] divisor,
  output logic                        done,
  output logic [smau_pkg::WORD_W-1:0] quotient,
  output logic [smau_pkg::WORD_W-1:0] remainder
);
  import smau_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [WORD_W-1:0]     quo;
  logic [WORD_W-1:0]     rem;
  logic [WORD_W-1:0]     dvs;
  logic                  neg_q;
  logic                  neg_r;
  logic [WORD_W:0]       rem_sh;
  logic [WORD_W:0]       diff;

  assign rem_sh = {rem, quo[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  // magnitudes of the most negative word come out right as unsigned
  assign quotient  = neg_q ? -quo : quo;
  assign remainder = neg_r ? -rem : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        quo   <= dividend[WORD_W-1] ? -dividend : dividend;
        dvs   <= divisor[WORD_W-1] ? -divisor : divisor;
        rem   <= '0;
        neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        neg_r <= dividend[WORD_W-1];
      end else if (busy) begin
        if (!diff[WORD_W]) begin
          rem <= diff[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == DIV_STEP_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/stack_machine_arith_unit.sv =====
// stack machine arithmetic unit: bounded word stack with push and integer ops
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  opcode, push_value
//   m_*      out        m_tvalid/m_tready  status, top_value, entry_count
//
// the top entry lives in a register, the rest in a 256-word memory read once on
// accept; push, add, sub and mul pass through S_EXEC and S_DONE, while div and
// mod that reach the 32-step divider also wait in S_DIV. one instruction is in
// flight at a time: s_tready is high only in S_IDLE, which the unit re-enters
// as it commits the result. reset empties the stack at once.
// a held output stalls the commit, and with it the next accept.
module stack_machine_arith_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [2:0] opcode, [34:3] push_value, rest zero
  input  logic [smau_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [1:0] status, [33:2] top_value, [42:34] entry_count, rest zero
  output logic [smau_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import smau_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DONE} state_t;

  state_t            state;
  logic [CNT_W-1:0]  depth;
  logic [WORD_W-1:0] top_word;
  logic [WORD_W-1:0] s_word;
  opcode_t           op;
  logic [WORD_W-1:0] pv;
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

  status_t           res_status;
  logic [WORD_W-1:0] res_value;
  logic              res_push;
  logic              res_pop;

  status_t           ex_status;
  logic [WORD_W-1:0] ex_value;
  logic              ex_push;
  logic              ex_pop;
  logic              ex_div;

  logic              in_fire;
  logic              out_free;
  logic              commit;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  depth_next;
  logic [WORD_W-1:0] top_next;
  logic [WORD_W-1:0] top_out;

  logic              div_done;
  logic [WORD_W-1:0] quotient;
  logic [WORD_W-1:0] remainder;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == S_DONE) && out_free;

  // second entry sits just below the top register
  assign rd_addr = ADDR_W'(depth - CNT_W'(2));
  assign wr_addr = ADDR_W'(depth - CNT_W'(1));

  always_comb begin
    ex_status = ST_OK;
    ex_value  = top_word;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_div    = 1'b0;
    case (op)
      OP_PUSH: begin
        ex_value = pv;
        if (depth == CNT_W'(STACK_DEPTH)) ex_status = ST_FULL;
        else ex_push = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        if (depth < CNT_W'(MIN_OPERANDS)) begin
          ex_status = ST_SHORT;
        end else begin
          ex_pop = 1'b1;
          case (op)
            OP_ADD:  ex_value = s_word + top_word;
            OP_SUB:  ex_value = s_word - top_word;
            default: ex_value = s_word * top_word;
          endcase
        end
      end
      OP_DIV, OP_MOD: begin
        if (depth < CNT_W'(MIN_OPERANDS)) ex_status = ST_SHORT;
        else if (top_word == '0) ex_status = ST_DIVZERO;
        else ex_div = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    depth_next = depth;
    if (res_push) depth_next = depth + CNT_W'(1);
    else if (res_pop) depth_next = depth - CNT_W'(1);
  end

  assign top_next = (res_push || res_pop) ? res_value : top_word;
  assign top_out  = (depth_next == '0) ? '0 : top_next;

  smau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     ((state == S_EXEC) && ex_div),
    .dividend  (s_word),
    .divisor   (top_word),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // stack memory: read second entry on accept, spill old top on push
  always_ff @(posedge clk) begin
    if (in_fire) s_word <= stack_mem[rd_addr];
    if (commit && res_push && (depth != '0)) stack_mem[wr_addr] <= top_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      depth    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (commit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op    <= opcode_t'(s_tdata[OP_W-1:0]);
            pv    <= s_tdata[OP_W +: WORD_W];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= ex_status;
          res_value  <= ex_value;
          res_push   <= ex_push;
          res_pop    <= ex_pop || ex_div;
          state      <= ex_div ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            res_value <= (op == OP_DIV) ? quotient : remainder;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            depth    <= depth_next;
            top_word <= top_next;
            m_tdata  <= OUT_TDATA_W'({COUNT_OUT_W'(depth_next), top_out, res_status});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/stack_machine_arith_unit_tb.sv =====
// testbench for the stack machine arithmetic unit: random stream traffic against a stack predictor
`timescale 1ns / 100ps

module stack_machine_arith_unit_tb;
  import smau_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int GAP_PERCENT  = 19;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct {
    status_t                  status;
    logic [WORD_W-1:0]        top_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } stack_result_t;

  class stack_tracker;
    logic [WORD_W-1:0] words [STACK_DEPTH];
    int                depth;
    stack_result_t     pending_results [$];
    int                mismatches;

    function new();
      depth      = 0;
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // apply one accepted instruction to the stack and queue the result it gives
    function void note_instruction(logic [OP_W-1:0] op, logic [WORD_W-1:0] pv);
      stack_result_t     res;
      status_t           st;
      logic [WORD_W-1:0] s, t, r;
      longint            ss, ts;
      st = ST_OK;
      if (op == OP_PUSH) begin
        if (depth >= STACK_DEPTH) begin
          st = ST_FULL;
        end else begin
          words[depth] = pv;
          depth++;
        end
      end else if (op <= OP_MOD) begin
        if (depth < MIN_OPERANDS) begin
          st = ST_SHORT;
        end else begin
          t = words[depth-1];
          s = words[depth-2];
          if ((op == OP_DIV || op == OP_MOD) && t == '0) begin
            st = ST_DIVZERO;
          end else begin
            ss = longint'($signed(s));
            ts = longint'($signed(t));
            case (op)
              OP_ADD:  r = s + t;
              OP_SUB:  r = s - t;
              OP_MUL:  r = s * t;
              OP_DIV:  r = 32'(ss / ts);
              default: r = 32'(ss % ts);
            endcase
            depth--;
            words[depth-1] = r;
          end
        end
      end
      res.status      = st;
      res.top_value   = (depth > 0) ? words[depth-1] : '0;
      res.entry_count = COUNT_OUT_W'(depth);
      pending_results.push_back(res);
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] d);
      stack_result_t exp_res;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tdata %h", d));
      end else begin
        exp_res = pending_results.pop_front();
        if (d[1:0] != exp_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", d[1:0], exp_res.status));
        if (d[33:2] != exp_res.top_value)
          report_mismatch($sformatf("top_value %h, expected %h", d[33:2], exp_res.top_value));
        if (d[42:34] != exp_res.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", d[42:34],
                                    exp_res.entry_count));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  stack_tracker tracker;
  bit           no_gaps;
  int           random_sent;

  stack_machine_arith_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // called at a rising edge; returns at the edge where the transaction is taken
  task send_instruction(logic [OP_W-1:0] op, logic [WORD_W-1:0] pv);
    while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, pv, op};
    do @(posedge clk); while (!s_tready);
    tracker.note_instruction(op, pv);
  endtask

  task take_results();
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready)
        tracker.check_result(m_tdata);
      m_tready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end
  endtask

  function logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      5, 6:    pick_word = WORD_W'(int'($urandom_range(8)) - 4);
      7:       pick_word = WORD_MIN;
      8:       pick_word = WORD_MAX;
      9:       pick_word = WORD_W'(int'($urandom_range(2)) - 1);
      default: pick_word = $urandom;
    endcase
  endfunction

  // push_percent steers the stack depth: high fills, low drains
  function logic [OP_W-1:0] pick_op(int push_percent);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_percent)
      pick_op = OP_PUSH;
    else if (roll < 95)
      pick_op = OP_W'($urandom_range(OP_MOD, OP_ADD));
    else
      pick_op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
  endfunction

  task run_directed();
    send_instruction(OP_ADD,  $urandom);   // empty stack
    send_instruction(OP_DIV,  $urandom);
    send_instruction(OP_PUSH, WORD_MAX);
    send_instruction(OP_MUL,  $urandom);   // one entry only
    send_instruction(OP_PUSH, 32'd1);
    send_instruction(OP_ADD,  '0);         // wraps to the most negative word
    send_instruction(OP_PUSH, '1);
    send_instruction(OP_DIV,  '0);         // overflowing quotient
    send_instruction(OP_PUSH, '1);
    send_instruction(OP_MOD,  '0);         // remainder of the overflow case
    send_instruction(OP_DIV,  '0);         // short stack wins over zero divisor
    send_instruction(OP_PUSH, -32'sd7);
    send_instruction(OP_PUSH, '0);
    send_instruction(OP_DIV,  '0);
    send_instruction(OP_MOD,  '0);
    send_instruction(OP_SUB,  '0);
    send_instruction(OP_PUSH, 32'd2);
    send_instruction(OP_MOD,  '0);         // remainder follows the dividend sign
    send_instruction(OP_PUSH, 32'd5);
    send_instruction(OP_SUB,  '0);         // second minus top
    send_instruction(OP_PUSH, 32'd3);
    send_instruction(OP_MUL,  '0);
    send_instruction(OP_DIV,  '0);
    send_instruction(OP_SPARE_A, $urandom);
    send_instruction(OP_SPARE_B, $urandom);
  endtask

  task run_random();
    int burst;
    int push_percent;
    burst       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      no_gaps = (random_sent >= 400 && random_sent < 600);
      if (burst % 12 == 5) begin
        // fill to the top, then bump into the limit a few times
        while (tracker.depth < STACK_DEPTH) begin
          send_instruction(OP_PUSH, pick_word());
          random_sent++;
        end
        repeat (3) begin
          send_instruction(OP_PUSH, pick_word());
          random_sent++;
        end
      end else begin
        push_percent = (burst % 12 >= 8) ? 10 : 45;
        repeat (20) begin
          send_instruction(pick_op(tracker.depth < MIN_OPERANDS ? 70 : push_percent),
                           pick_word());
          random_sent++;
        end
      end
      burst++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    tracker  = new();
    no_gaps  = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    m_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none
    run_directed();
    run_random();
    s_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
